// File: design/mpns_pkg.sv
// Package: shared types, constants and saturating helpers of the modal plate block.
`default_nettype none
package mpns_pkg;

  localparam int MAX_MODES_DEF = 1024;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [15:0] NONLIN_A_RST   = 16'd7680;
  localparam logic [15:0] INPUT_GAIN_RST = 16'd10000;
  localparam logic [10:0] MODES_USED_RST = 11'd1024;

  localparam logic signed [63:0] WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q24  = 64'sd16777216;

  typedef enum logic [CFG_IW-1:0] {
    REG_NONLIN_A   = 2'd0,
    REG_INPUT_GAIN = 2'd1,
    REG_MODES_USED = 2'd2
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_RUN   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    OP_ETA   = 4'd0,
    OP_E2    = 4'd1,
    OP_SA    = 4'd2,
    OP_SALAM = 4'd3,
    OP_OM2   = 4'd4,
    OP_OMP   = 4'd5,
    OP_OMQ   = 4'd6,
    OP_SGETA = 4'd7,
    OP_DAMP  = 4'd8,
    OP_EXC   = 4'd9,
    OP_C1B1  = 4'd10,
    OP_OMB2  = 4'd11,
    OP_OMB1  = 4'd12,
    OP_QN    = 4'd13,
    OP_PN    = 4'd14,
    OP_OUT   = 4'd15
  } op_t;

  typedef struct packed {
    logic              mode;
    logic [9:0]        mode_index;
    logic signed [31:0] freq_coeff;
    logic signed [31:0] damp_coeff;
    logic signed [31:0] in_weight;
    logic signed [31:0] out_weight;
    logic signed [23:0] excitation;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_sample;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] addw(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(WIDE_MAX)) return WIDE_MAX;
    if (s < -65'(WIDE_MAX)) return -WIDE_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage
`default_nettype wire

// File: design/mpns_chan_if.sv
// Valid/ready channel carrying one item.
`default_nettype none
interface mpns_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/mpns_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module mpns_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                  wdata,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output      logic [W-1:0]                  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/modal_plate_nonlinear_step.sv
// Modal plate reverb with nonlinear damping: sequencer over mode state and coefficient RAMs.
// Load item: written straight into both RAMs.
// Sample item: a read and a fetch state, then 16 ops on one 4-pass 32x32 multiplier
//   per mode in use; no new item is taken until the result is issued.
// The reciprocal divider overlaps the multiplier ops of the same mode; QN waits for it.
// Reset (rst, synchronous): clearing pass over all MAX_MODES entries of the state RAM, no
//   items accepted meanwhile; config writes are taken throughout.
`default_nettype none
module modal_plate_nonlinear_step #(
  parameter int MAX_MODES = mpns_pkg::MAX_MODES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [mpns_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [mpns_pkg::CFG_DW-1:0] cfg_data,
  mpns_chan_if.sink                       item_in,
  mpns_chan_if.source                     item_out
);
  localparam int AW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int CW = $clog2(MAX_MODES + 1);

  mpns_pkg::state_t state;
  mpns_pkg::op_t    step;
  logic [AW-1:0] m;
  logic [CW-1:0] n_lim;
  logic [CW-1:0] n_sel;

  logic [15:0] nonlin_a, input_gain;
  logic [10:0] modes_used;

  logic signed [41:0] exc;
  logic signed [31:0] q, p, om, sg, gi, ow, eta, qn;
  logic signed [63:0] e2, sa, c1, b1, b2, tmp, qsum, psum, recip, acc;
  logic signed [63:0] lam, lm2d, det;
  logic signed [31:0] osample;
  logic ov;

  logic in_acc, load_ok, wb_pn;
  logic st_we;
  logic [AW-1:0] st_wa, ld_addr;
  logic [63:0] st_wd, st_rd;
  logic [127:0] cf_rd;

  // multiplier
  logic issue, mbusy, mdone, mneg;
  logic [2:0] mcnt;
  logic [1:0] mpk;
  logic [5:0] msh;
  logic [63:0] mx, my, mprod, rmag;
  logic [31:0] xs, ys;
  logic [127:0] macc, mshifted;
  logic signed [63:0] mres, op_x, op_y;
  logic [5:0] op_sh;

  // divider
  logic div_start, dbusy, dneg;
  logic [5:0] dcnt;
  logic [63:0] dmag, drem, rem2;
  logic [54:0] dq;

  assign in_acc  = item_in.valid && item_in.ready;
  assign load_ok = in_acc && !item_in.payload.mode &&
                   (int'(item_in.payload.mode_index) < MAX_MODES);
  assign ld_addr = AW'(item_in.payload.mode_index);
  assign item_in.ready = (state == mpns_pkg::ST_IDLE);
  assign item_out.valid = ov;
  assign item_out.payload.out_sample = osample;

  assign n_sel = (int'(modes_used) > MAX_MODES) ? CW'(MAX_MODES) : CW'(modes_used);
  assign lam   = mpns_pkg::ONE_Q24 + (e2 <<< 1) + e2;
  assign lm2d  = e2 - mpns_pkg::ONE_Q24;
  assign det   = mpns_pkg::addw(c1, mres);
  assign wb_pn = (state == mpns_pkg::ST_RUN) && mdone && (step == mpns_pkg::OP_PN);
  assign div_start = (state == mpns_pkg::ST_RUN) && mdone && (step == mpns_pkg::OP_OM2);
  assign issue = (state == mpns_pkg::ST_RUN) && !mbusy && !mdone &&
                 !((step == mpns_pkg::OP_QN) && dbusy);

  always_comb begin
    st_we = 1'b0;
    st_wa = m;
    st_wd = '0;
    if (state == mpns_pkg::ST_CLEAR) begin
      st_we = 1'b1;
    end else if (load_ok) begin
      st_we = 1'b1;
      st_wa = ld_addr;
    end else if (wb_pn) begin
      st_we = 1'b1;
      st_wd = {qn, mpns_pkg::sat32(mres)};
    end
  end

  mpns_ram #(.W(64), .D(MAX_MODES)) u_state_ram (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(m), .rdata(st_rd)
  );

  mpns_ram #(.W(128), .D(MAX_MODES)) u_coef_ram (
    .clk(clk), .we(load_ok), .waddr(ld_addr),
    .wdata({item_in.payload.freq_coeff, item_in.payload.damp_coeff,
            item_in.payload.in_weight, item_in.payload.out_weight}),
    .raddr(m), .rdata(cf_rd)
  );

  always_comb begin
    op_x  = 64'(q);
    op_y  = 64'(p);
    op_sh = 6'd30;
    unique case (step)
      mpns_pkg::OP_ETA:   begin op_x = {48'b0, nonlin_a}; op_y = 64'(p); op_sh = 6'd8; end
      mpns_pkg::OP_E2:    begin op_x = 64'(eta); op_y = 64'(eta); op_sh = 6'd24; end
      mpns_pkg::OP_SA:    begin op_x = 64'(sg); op_y = {48'b0, nonlin_a}; op_sh = 6'd14; end
      mpns_pkg::OP_SALAM: begin op_x = sa; op_y = lam; op_sh = 6'd24; end
      mpns_pkg::OP_OM2:   begin op_x = 64'(om); op_y = 64'(om); op_sh = 6'd36; end
      mpns_pkg::OP_OMP:   begin op_x = 64'(om); op_y = 64'(p); end
      mpns_pkg::OP_OMQ:   begin op_x = 64'(om); op_y = 64'(q); end
      mpns_pkg::OP_SGETA: begin op_x = 64'(sg); op_y = 64'(eta); end
      mpns_pkg::OP_DAMP:  begin op_x = tmp; op_y = lm2d; op_sh = 6'd24; end
      mpns_pkg::OP_EXC:   begin op_x = 64'(gi); op_y = 64'(exc); end
      mpns_pkg::OP_C1B1:  begin op_x = c1; op_y = b1; op_sh = 6'd24; end
      mpns_pkg::OP_OMB2:  begin op_x = 64'(om); op_y = b2; end
      mpns_pkg::OP_OMB1:  begin op_x = 64'(om); op_y = b1; end
      mpns_pkg::OP_QN:    begin op_x = recip; op_y = qsum; end
      mpns_pkg::OP_PN:    begin op_x = recip; op_y = psum; end
      mpns_pkg::OP_OUT:   begin op_x = 64'(qn); op_y = 64'(ow); end
      default:            begin op_x = '0; op_y = '0; end
    endcase
  end

  // four 32x32 partials, each registered before it is accumulated, then shift and saturate
  assign xs = mcnt[0] ? mx[63:32] : mx[31:0];
  assign ys = mcnt[1] ? my[63:32] : my[31:0];
  assign mshifted = macc >> msh;
  assign rmag = (|mshifted[127:62]) ? 64'(mpns_pkg::WIDE_MAX) : mshifted[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      mcnt  <= '0;
    end else begin
      mdone <= 1'b0;
      if (issue) begin
        mbusy <= 1'b1;
        mcnt  <= '0;
        macc  <= '0;
        mx    <= mpns_pkg::abs64(op_x);
        my    <= mpns_pkg::abs64(op_y);
        mneg  <= op_x[63] ^ op_y[63];
        msh   <= op_sh;
      end else if (mbusy) begin
        mcnt <= mcnt + 3'd1;
        if (mcnt < 3'd4) begin
          mprod <= xs * ys;
          mpk   <= mcnt[1:0];
        end
        if (mcnt != 3'd0 && mcnt < 3'd5) begin
          macc <= macc + (128'(mprod) << {mpk[0] & mpk[1], mpk[0] ^ mpk[1], 5'b0});
        end
        if (mcnt == 3'd5) begin
          mres  <= mneg ? -$signed(rmag) : $signed(rmag);
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  // restoring divider for 2^54 / |det|
  assign rem2 = {drem[62:0], dcnt == 6'd54};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (div_start) begin
      if (det == 64'sd0) begin
        recip <= mpns_pkg::WIDE_MAX;
      end else begin
        dbusy <= 1'b1;
        dmag  <= mpns_pkg::abs64(det);
        dneg  <= det[63];
        drem  <= '0;
        dq    <= '0;
        dcnt  <= 6'd54;
      end
    end else if (dbusy) begin
      if (rem2 >= dmag) begin
        drem <= rem2 - dmag;
      end else begin
        drem <= rem2;
      end
      dq   <= {dq[53:0], rem2 >= dmag};
      dcnt <= dcnt - 6'd1;
      if (dcnt == 6'd0) begin
        dbusy <= 1'b0;
        recip <= dneg ? -$signed(64'({dq[53:0], rem2 >= dmag}))
                      : $signed(64'({dq[53:0], rem2 >= dmag}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mpns_pkg::ST_CLEAR;
      step       <= mpns_pkg::OP_ETA;
      m          <= '0;
      ov         <= 1'b0;
      nonlin_a   <= mpns_pkg::NONLIN_A_RST;
      input_gain <= mpns_pkg::INPUT_GAIN_RST;
      modes_used <= mpns_pkg::MODES_USED_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mpns_pkg::REG_NONLIN_A:   nonlin_a   <= cfg_data;
          mpns_pkg::REG_INPUT_GAIN: input_gain <= cfg_data;
          mpns_pkg::REG_MODES_USED: modes_used <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (item_out.valid && item_out.ready && (state != mpns_pkg::ST_FIN)) begin
        ov <= 1'b0;
      end
      unique case (state)
        mpns_pkg::ST_CLEAR: begin
          if (m == AW'(MAX_MODES - 1)) begin
            m     <= '0;
            state <= mpns_pkg::ST_IDLE;
          end else begin
            m <= m + 1'b1;
          end
        end
        mpns_pkg::ST_IDLE: begin
          if (in_acc && item_in.payload.mode) begin
            m     <= '0;
            acc   <= '0;
            n_lim <= n_sel;
            exc   <= 42'($signed(item_in.payload.excitation)) *
                     42'($signed({1'b0, input_gain})) <<< 1;
            state <= (n_sel == '0) ? mpns_pkg::ST_FIN : mpns_pkg::ST_READ;
          end
        end
        mpns_pkg::ST_READ: state <= mpns_pkg::ST_FETCH;
        mpns_pkg::ST_FETCH: begin
          q  <= st_rd[63:32];
          p  <= st_rd[31:0];
          om <= cf_rd[127:96];
          sg <= cf_rd[95:64];
          gi <= cf_rd[63:32];
          ow <= cf_rd[31:0];
          step  <= mpns_pkg::OP_ETA;
          state <= mpns_pkg::ST_RUN;
        end
        mpns_pkg::ST_RUN: begin
          if (mdone) begin
            case (step)
              mpns_pkg::OP_ETA:   eta  <= mpns_pkg::sat32(mres);
              mpns_pkg::OP_E2:    e2   <= mres;
              mpns_pkg::OP_SA:    sa   <= mres;
              mpns_pkg::OP_SALAM: c1   <= mpns_pkg::addw(mpns_pkg::ONE_Q24, mres);
              mpns_pkg::OP_OMP:   b1   <= mpns_pkg::addw(64'(q), mres);
              mpns_pkg::OP_OMQ:   b2   <= mpns_pkg::addw(-mres, 64'(p));
              mpns_pkg::OP_SGETA: tmp  <= mres;
              mpns_pkg::OP_DAMP:  b2   <= mpns_pkg::addw(b2, mres);
              mpns_pkg::OP_EXC:   b2   <= mpns_pkg::addw(b2, mres);
              mpns_pkg::OP_C1B1:  tmp  <= mres;
              mpns_pkg::OP_OMB2:  qsum <= mpns_pkg::addw(tmp, mres);
              mpns_pkg::OP_OMB1:  psum <= mpns_pkg::addw(b2, -mres);
              mpns_pkg::OP_QN:    qn   <= mpns_pkg::sat32(mres);
              mpns_pkg::OP_OUT:   acc  <= mpns_pkg::addw(acc, mres);
              default: ;
            endcase
            if (step == mpns_pkg::OP_OUT) begin
              if (CW'(m) + CW'(1) == n_lim) begin
                state <= mpns_pkg::ST_FIN;
              end else begin
                m     <= m + 1'b1;
                state <= mpns_pkg::ST_READ;
              end
            end else begin
              step <= mpns_pkg::op_t'(step + 4'd1);
            end
          end
        end
        mpns_pkg::ST_FIN: begin
          if (!ov || item_out.ready) begin
            ov      <= 1'b1;
            osample <= mpns_pkg::sat32(acc);
            state   <= mpns_pkg::ST_IDLE;
          end
        end
        default: state <= mpns_pkg::ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/mpns_check.sv
// Port-level checker for the modal plate block, bound to the top level.
`default_nettype none
module mpns_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_mode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_sample
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_sample)) else $error("result changed while stalled");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode |=> !in_ready) else $error("sample item did not start a sweep");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_mode && !out_valid |=> !out_valid)
    else $error("load item produced a result");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready) else $error("item taken during clearing pass");
endmodule

bind modal_plate_nonlinear_step mpns_check u_check (
  .clk(clk), .rst(rst),
  .in_valid(item_in.valid), .in_ready(item_in.ready), .in_mode(item_in.payload.mode),
  .out_valid(item_out.valid), .out_ready(item_out.ready),
  .out_sample(item_out.payload.out_sample)
);
`default_nettype wire
